FILE: design/modular_combinatorics_engine_top_assert.svh
// Assertion macros for the engine's RTL, included by the multiplier
`ifndef MODULAR_COMBINATORICS_ENGINE_TOP_ASSERT_SVH
`define MODULAR_COMBINATORICS_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define MCE_ASSERT(lbl, prop, msg)
`define MCE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: design/mce_pkg.sv
// Shared types, constants and modular helpers of the combinatorics engine
package mce_pkg;

  localparam int unsigned DEF_TABLE_SIZE = 1024;
  localparam int unsigned VW = 30;
  localparam int unsigned NW = 63;
  localparam int unsigned KW = 10;
  localparam int unsigned CW = 3;

  localparam logic [VW-1:0] PRIME    = 30'd1000000007;
  localparam logic [NW-1:0] PRIME_M2 = 63'd1000000005;

  typedef enum logic [CW-1:0] {
    CMD_C     = 3'd0,
    CMD_P     = 3'd1,
    CMD_H     = 3'd2,
    CMD_LCOMB = 3'd3,
    CMD_SURJ  = 3'd4,
    CMD_BELL  = 3'd5
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_ARGS, OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_REDUCE, OP_READ,
    OP_WR_FACT, OP_WR_FINV, OP_I_ZERO, OP_I_TOP, OP_I_M, OP_I_INC, OP_I_DEC,
    OP_E_N, OP_E_PM2, OP_E_SHR
  } dp_op_e;

  typedef enum logic [2:0] {
    R_ACC, R_TMP, R_BASE, R_POW, R_DEN, R_PREF
  } reg_e;

  typedef enum logic [3:0] {
    S_ACC, S_TMP, S_BASE, S_POW, S_DEN, S_PREF, S_ZERO, S_ONE,
    S_FACT, S_FINV, S_I, S_IP1, S_NMI, S_KMI
  } src_e;

  typedef enum logic [2:0] {
    A_I, A_N, A_NMK, A_K, A_A, A_AMK, A_KMI, A_J
  } addr_e;

  typedef struct packed {
    dp_op_e op;
    reg_e   dst;
    src_e   sa;
    src_e   sb;
    addr_e  addr;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic n_lt_k;
    logic n_big;
    logic n_zero;
    logic k_zero;
    logic a_big;
    logic k_big;
    logic m_big;
    logic i_zero;
    logic i_eq_k;
    logic i_eq_ts;
    logic i_odd;
    logic j_zero;
    logic j_odd;
    logic e_zero;
    logic e_odd;
  } dp_stat_t;

  function automatic logic [VW-1:0] add_mod(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    logic [VW:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= {1'b0, PRIME}) ? s - {1'b0, PRIME} : s;
    return r[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sub_mod(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] r;
    r = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
    return r[VW-1:0];
  endfunction

endpackage

FILE: design/mce_ifs.sv
// Query and result channel interfaces
interface mce_in_if;
  logic                       valid;
  logic                       ready;
  logic [mce_pkg::CW-1:0]     cmd;
  logic [mce_pkg::NW-1:0]     n;
  logic [mce_pkg::KW-1:0]     k;
  modport source (output valid, cmd, n, k, input ready);
  modport sink   (input valid, cmd, n, k, output ready);
endinterface

interface mce_out_if;
  logic                       valid;
  logic                       ready;
  logic [mce_pkg::VW-1:0]     value;
  logic                       status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

FILE: design/mce_mulmod.sv
// Bit-serial modular multiplier / reducer, one operand bit per cycle
`include "modular_combinatorics_engine_top_assert.svh"
module mce_mulmod (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [mce_pkg::VW-1:0] a_i,
  input  logic [mce_pkg::NW-1:0] b_i,
  input  logic [5:0]             len_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [mce_pkg::VW-1:0] res_o
);

  logic [mce_pkg::VW-1:0] r_q, a_q;
  logic [mce_pkg::NW-1:0] b_q;
  logic [5:0]             cnt_q;
  logic                   busy_q, done_q;
  logic [mce_pkg::VW:0]   dbl, red1, sum, nxt;

  // r = 2r + bit*a, both steps kept below the modulus
  always_comb begin
    dbl  = {r_q, 1'b0};
    red1 = (dbl >= {1'b0, mce_pkg::PRIME}) ? dbl - {1'b0, mce_pkg::PRIME} : dbl;
    sum  = red1 + (b_q[mce_pkg::NW-1] ? {1'b0, a_q} : '0);
    nxt  = (sum >= {1'b0, mce_pkg::PRIME}) ? sum - {1'b0, mce_pkg::PRIME} : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      a_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        r_q    <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        cnt_q  <= len_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        r_q   <= nxt[mce_pkg::VW-1:0];
        b_q   <= {b_q[mce_pkg::NW-2:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = r_q;

  `MCE_ASSERT(a_no_restart, !(start_i && busy_q), "multiplier started while busy")
  `MCE_ASSERT_IMP(a_res_reduced, done_q, r_q < mce_pkg::PRIME, "result not reduced")
  `MCE_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q), "done without a run")

endmodule

FILE: design/mce_datapath.sv
// Datapath: tables, working registers, index and exponent counters, multiplier
module mce_datapath #(
  parameter int unsigned TABLE_SIZE = mce_pkg::DEF_TABLE_SIZE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mce_pkg::dp_cmd_t       cmd_i,
  output mce_pkg::dp_stat_t      stat_o,
  input  logic [mce_pkg::NW-1:0] n_i,
  input  logic [mce_pkg::KW-1:0] k_i,
  output logic [mce_pkg::VW-1:0] value_o
);

  localparam int unsigned VW  = mce_pkg::VW;
  localparam int unsigned NW  = mce_pkg::NW;
  localparam int unsigned KW  = mce_pkg::KW;
  localparam int unsigned AW  = $clog2(TABLE_SIZE);
  localparam int unsigned IW  = ((AW > KW) ? AW : KW) + 1;
  localparam logic [NW-1:0] TS_N  = NW'(TABLE_SIZE);
  localparam logic [IW-1:0] TS_I  = IW'(TABLE_SIZE);
  localparam logic [IW-1:0] TOP_I = IW'(TABLE_SIZE - 1);

  logic [VW-1:0] fact_mem [TABLE_SIZE];
  logic [VW-1:0] finv_mem [TABLE_SIZE];

  logic [NW-1:0] n_q, e_q;
  logic [KW-1:0] k_q;
  logic [IW-1:0] m_q, i_q;
  logic [VW-1:0] acc_q, tmp_q, base_q, pow_q, den_q, pref_q, nr_q;
  logic [VW-1:0] fact_rd_q, finv_rd_q;
  mce_pkg::reg_e mdst_q;
  logic          mred_q;

  logic [IW-1:0] k_x, kmi, j_x, n_lo;
  logic [NW:0]   a_full;
  logic [VW-1:0] i_v;
  logic [VW:0]   nmi_w;
  logic [VW-1:0] srcv [16];
  logic [VW-1:0] va, vb;
  logic [AW-1:0] raddr;
  logic          mm_start, mm_busy, mm_done;
  logic [VW-1:0] mm_a, mm_res;
  logic [NW-1:0] mm_b;
  logic [5:0]    mm_len;
  logic          wr_en;
  mce_pkg::reg_e wr_dst;
  logic [VW-1:0] wr_val;

  always_comb begin
    k_x    = {{(IW-KW){1'b0}}, k_q};
    n_lo   = n_q[IW-1:0];
    kmi    = k_x - i_q;
    j_x    = m_q - i_q;
    a_full = {1'b0, n_q} + {{(NW+1-KW){1'b0}}, k_q} - {{NW{1'b0}}, 1'b1};
    i_v    = {{(VW-IW){1'b0}}, i_q};
    nmi_w  = (nr_q >= i_v) ? {1'b0, nr_q} - {1'b0, i_v}
                           : {1'b0, nr_q} + {1'b0, mce_pkg::PRIME} - {1'b0, i_v};
  end

  always_comb begin
    srcv[mce_pkg::S_ACC]  = acc_q;
    srcv[mce_pkg::S_TMP]  = tmp_q;
    srcv[mce_pkg::S_BASE] = base_q;
    srcv[mce_pkg::S_POW]  = pow_q;
    srcv[mce_pkg::S_DEN]  = den_q;
    srcv[mce_pkg::S_PREF] = pref_q;
    srcv[mce_pkg::S_ZERO] = '0;
    srcv[mce_pkg::S_ONE]  = {{(VW-1){1'b0}}, 1'b1};
    srcv[mce_pkg::S_FACT] = fact_rd_q;
    srcv[mce_pkg::S_FINV] = finv_rd_q;
    srcv[mce_pkg::S_I]    = i_v;
    srcv[mce_pkg::S_IP1]  = {{(VW-IW){1'b0}}, i_q + {{(IW-1){1'b0}}, 1'b1}};
    srcv[mce_pkg::S_NMI]  = nmi_w[VW-1:0];
    srcv[mce_pkg::S_KMI]  = {{(VW-IW){1'b0}}, kmi};
    srcv[14]              = '0;
    srcv[15]              = '0;
    va = srcv[cmd_i.sa];
    vb = srcv[cmd_i.sb];
  end

  always_comb begin
    case (cmd_i.addr)
      mce_pkg::A_N:   raddr = n_lo[AW-1:0];
      mce_pkg::A_NMK: raddr = n_lo[AW-1:0] - k_x[AW-1:0];
      mce_pkg::A_K:   raddr = k_x[AW-1:0];
      mce_pkg::A_A:   raddr = a_full[AW-1:0];
      mce_pkg::A_AMK: raddr = n_lo[AW-1:0] - {{(AW-1){1'b0}}, 1'b1};
      mce_pkg::A_KMI: raddr = kmi[AW-1:0];
      mce_pkg::A_J:   raddr = j_x[AW-1:0];
      default:        raddr = i_q[AW-1:0];
    endcase
  end

  assign mm_start = (cmd_i.op == mce_pkg::OP_MUL) || (cmd_i.op == mce_pkg::OP_REDUCE);
  assign mm_a     = (cmd_i.op == mce_pkg::OP_REDUCE) ? {{(VW-1){1'b0}}, 1'b1} : va;
  assign mm_b     = (cmd_i.op == mce_pkg::OP_REDUCE) ? n_q : {vb, {(NW-VW){1'b0}}};
  assign mm_len   = (cmd_i.op == mce_pkg::OP_REDUCE) ? 6'(NW) : 6'(VW);

  mce_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .len_i   (mm_len),
    .busy_o  (mm_busy),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = cmd_i.dst;
    wr_val = va;
    if (mm_done) begin
      wr_en  = !mred_q;
      wr_dst = mdst_q;
      wr_val = mm_res;
    end else begin
      case (cmd_i.op)
        mce_pkg::OP_LOAD: wr_en = 1'b1;
        mce_pkg::OP_ADD: begin
          wr_en  = 1'b1;
          wr_val = mce_pkg::add_mod(va, vb);
        end
        mce_pkg::OP_SUB: begin
          wr_en  = 1'b1;
          wr_val = mce_pkg::sub_mod(va, vb);
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (wr_dst)
        mce_pkg::R_ACC:  acc_q  <= wr_val;
        mce_pkg::R_TMP:  tmp_q  <= wr_val;
        mce_pkg::R_BASE: base_q <= wr_val;
        mce_pkg::R_POW:  pow_q  <= wr_val;
        mce_pkg::R_DEN:  den_q  <= wr_val;
        default:         pref_q <= wr_val;
      endcase
    end
    if (mm_done && mred_q) begin
      nr_q <= mm_res;
    end
    if (mm_start) begin
      mdst_q <= cmd_i.dst;
      mred_q <= (cmd_i.op == mce_pkg::OP_REDUCE);
    end
    case (cmd_i.op)
      mce_pkg::OP_ARGS: begin
        n_q <= n_i;
        k_q <= k_i;
        m_q <= (n_i < {{(NW-KW){1'b0}}, k_i}) ? {{(IW-KW){1'b0}}, n_i[KW-1:0]}
                                               : {{(IW-KW){1'b0}}, k_i};
      end
      mce_pkg::OP_I_ZERO: i_q <= '0;
      mce_pkg::OP_I_TOP:  i_q <= TOP_I;
      mce_pkg::OP_I_M:    i_q <= m_q;
      mce_pkg::OP_I_INC:  i_q <= i_q + {{(IW-1){1'b0}}, 1'b1};
      mce_pkg::OP_I_DEC:  i_q <= i_q - {{(IW-1){1'b0}}, 1'b1};
      mce_pkg::OP_E_N:    e_q <= n_q;
      mce_pkg::OP_E_PM2:  e_q <= mce_pkg::PRIME_M2;
      mce_pkg::OP_E_SHR:  e_q <= {1'b0, e_q[NW-1:1]};
      default: ;
    endcase
  end

  // tables: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == mce_pkg::OP_WR_FACT) begin
      fact_mem[i_q[AW-1:0]] <= va;
    end
    if (cmd_i.op == mce_pkg::OP_WR_FINV) begin
      finv_mem[i_q[AW-1:0]] <= va;
    end
    if (cmd_i.op == mce_pkg::OP_READ) begin
      fact_rd_q <= fact_mem[raddr];
      finv_rd_q <= finv_mem[raddr];
    end
  end

  always_comb begin
    stat_o.mul_busy = mm_busy || mm_done;
    stat_o.n_lt_k   = n_q < {{(NW-KW){1'b0}}, k_q};
    stat_o.n_big    = n_q >= TS_N;
    stat_o.n_zero   = (n_q == '0);
    stat_o.k_zero   = (k_q == '0);
    stat_o.a_big    = a_full >= {1'b0, TS_N};
    stat_o.k_big    = k_x >= TS_I;
    stat_o.m_big    = m_q >= TS_I;
    stat_o.i_zero   = (i_q == '0);
    stat_o.i_eq_k   = (i_q == k_x);
    stat_o.i_eq_ts  = (i_q == TS_I);
    stat_o.i_odd    = i_q[0];
    stat_o.j_zero   = (j_x == '0);
    stat_o.j_odd    = j_x[0];
    stat_o.e_zero   = (e_q == '0);
    stat_o.e_odd    = e_q[0];
  end

  assign value_o = acc_q;

endmodule

FILE: design/mce_ctrl.sv
// Controller: sequences table build, Fermat powers and per-command loops
module mce_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [mce_pkg::CW-1:0] in_cmd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   status_o,
  output mce_pkg::dp_cmd_t       dp_cmd_o,
  input  mce_pkg::dp_stat_t      stat_i
);

  typedef enum logic [6:0] {
    ST_IDLE, ST_WAIT, ST_DISP, ST_ZERO, ST_ONE, ST_OUT,
    ST_PW0, ST_POW, ST_POW_SQ, ST_POW_SH,
    ST_B0, ST_B1, ST_BFW, ST_BFI, ST_BFC, ST_BP0, ST_BP1,
    ST_BV0, ST_BV1, ST_BVW, ST_BVC, ST_BVD,
    ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5,
    ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7, ST_L8, ST_L9,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8, ST_S9,
    ST_S10, ST_S11, ST_S12,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8, ST_T9,
    ST_T10, ST_T11, ST_T12
  } state_e;

  state_e             state_q, state_d, ret_q, ret_d, pret_q, pret_d;
  mce_pkg::cmd_e      cmd_q, cmd_d;
  logic               tbl_rdy_q, tbl_rdy_d;
  logic               st_q, st_d;
  mce_pkg::dp_cmd_t   c;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    pret_d    = pret_q;
    cmd_d     = cmd_q;
    tbl_rdy_d = tbl_rdy_q;
    st_d      = st_q;
    c         = '{op: mce_pkg::OP_NOP, dst: mce_pkg::R_ACC, sa: mce_pkg::S_ZERO,
                  sb: mce_pkg::S_ZERO, addr: mce_pkg::A_I};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c.op    = mce_pkg::OP_ARGS;
          cmd_d   = mce_pkg::cmd_e'(in_cmd_i);
          st_d    = 1'b0;
          state_d = tbl_rdy_q ? ST_DISP : ST_B0;
        end
      end
      ST_WAIT: begin
        if (!stat_i.mul_busy) state_d = ret_q;
      end
      ST_DISP: begin
        case (cmd_q)
          mce_pkg::CMD_C, mce_pkg::CMD_P: begin
            if (stat_i.n_lt_k) state_d = ST_ZERO;
            else if (stat_i.n_big) begin
              st_d    = 1'b1;
              state_d = ST_ZERO;
            end else state_d = ST_C0;
          end
          mce_pkg::CMD_H: begin
            if (stat_i.n_zero && stat_i.k_zero) state_d = ST_ONE;
            else if (stat_i.n_zero) state_d = ST_ZERO;
            else if (stat_i.a_big) begin
              st_d    = 1'b1;
              state_d = ST_ZERO;
            end else state_d = ST_C0;
          end
          mce_pkg::CMD_LCOMB: state_d = stat_i.n_lt_k ? ST_ZERO : ST_L0;
          mce_pkg::CMD_SURJ: begin
            if (stat_i.k_big) begin
              st_d    = 1'b1;
              state_d = ST_ZERO;
            end else state_d = ST_S0;
          end
          mce_pkg::CMD_BELL: begin
            if (stat_i.n_zero) state_d = ST_ONE;
            else if (stat_i.m_big) begin
              st_d    = 1'b1;
              state_d = ST_ZERO;
            end else state_d = ST_T0;
          end
          default: state_d = ST_ZERO;
        endcase
      end
      ST_ZERO: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_ZERO;
        state_d = ST_OUT;
      end
      ST_ONE: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_ONE;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      // square-and-multiply: POW = BASE ^ e, then back to pret
      ST_PW0: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_POW; c.sa = mce_pkg::S_ONE;
        state_d = ST_POW;
      end
      ST_POW: begin
        if (stat_i.e_zero) state_d = pret_q;
        else if (stat_i.e_odd) begin
          c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_POW;
          c.sa = mce_pkg::S_POW; c.sb = mce_pkg::S_BASE;
          ret_d = ST_POW_SQ; state_d = ST_WAIT;
        end else state_d = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_BASE;
        c.sa = mce_pkg::S_BASE; c.sb = mce_pkg::S_BASE;
        ret_d = ST_POW_SH; state_d = ST_WAIT;
      end
      ST_POW_SH: begin
        c.op = mce_pkg::OP_E_SHR;
        state_d = ST_POW;
      end
      // table build, factorials upward then inverses downward
      ST_B0: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_TMP; c.sa = mce_pkg::S_ONE;
        state_d = ST_B1;
      end
      ST_B1: begin
        c.op = mce_pkg::OP_I_ZERO;
        state_d = ST_BFW;
      end
      ST_BFW: begin
        c.op = mce_pkg::OP_WR_FACT; c.sa = mce_pkg::S_TMP;
        state_d = ST_BFI;
      end
      ST_BFI: begin
        c.op = mce_pkg::OP_I_INC;
        state_d = ST_BFC;
      end
      ST_BFC: begin
        if (stat_i.i_eq_ts) state_d = ST_BP0;
        else begin
          c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
          c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_I;
          ret_d = ST_BFW; state_d = ST_WAIT;
        end
      end
      ST_BP0: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_BASE; c.sa = mce_pkg::S_TMP;
        state_d = ST_BP1;
      end
      ST_BP1: begin
        c.op = mce_pkg::OP_E_PM2;
        pret_d = ST_BV0; state_d = ST_PW0;
      end
      ST_BV0: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_TMP; c.sa = mce_pkg::S_POW;
        state_d = ST_BV1;
      end
      ST_BV1: begin
        c.op = mce_pkg::OP_I_TOP;
        state_d = ST_BVW;
      end
      ST_BVW: begin
        c.op = mce_pkg::OP_WR_FINV; c.sa = mce_pkg::S_TMP;
        state_d = ST_BVC;
      end
      ST_BVC: begin
        if (stat_i.i_zero) begin
          tbl_rdy_d = 1'b1;
          state_d   = ST_DISP;
        end else begin
          c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
          c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_I;
          ret_d = ST_BVD; state_d = ST_WAIT;
        end
      end
      ST_BVD: begin
        c.op = mce_pkg::OP_I_DEC;
        state_d = ST_BVW;
      end
      // C, P and H from the tables
      ST_C0: begin
        c.op = mce_pkg::OP_READ;
        c.addr = (cmd_q == mce_pkg::CMD_H) ? mce_pkg::A_A : mce_pkg::A_N;
        state_d = ST_C1;
      end
      ST_C1: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_FACT;
        state_d = ST_C2;
      end
      ST_C2: begin
        c.op = mce_pkg::OP_READ;
        c.addr = (cmd_q == mce_pkg::CMD_H) ? mce_pkg::A_AMK : mce_pkg::A_NMK;
        state_d = ST_C3;
      end
      ST_C3: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_ACC;
        c.sa = mce_pkg::S_ACC; c.sb = mce_pkg::S_FINV;
        ret_d = ST_C4; state_d = ST_WAIT;
      end
      ST_C4: begin
        if (cmd_q == mce_pkg::CMD_P) state_d = ST_OUT;
        else begin
          c.op = mce_pkg::OP_READ; c.addr = mce_pkg::A_K;
          state_d = ST_C5;
        end
      end
      ST_C5: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_ACC;
        c.sa = mce_pkg::S_ACC; c.sb = mce_pkg::S_FINV;
        ret_d = ST_OUT; state_d = ST_WAIT;
      end
      // large-n comb: running products, then one inverse
      ST_L0: begin
        c.op = mce_pkg::OP_REDUCE;
        ret_d = ST_L1; state_d = ST_WAIT;
      end
      ST_L1: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_ONE;
        state_d = ST_L2;
      end
      ST_L2: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_DEN; c.sa = mce_pkg::S_ONE;
        state_d = ST_L3;
      end
      ST_L3: begin
        c.op = mce_pkg::OP_I_ZERO;
        state_d = ST_L4;
      end
      ST_L4: begin
        if (stat_i.i_eq_k) state_d = ST_L7;
        else begin
          c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_ACC;
          c.sa = mce_pkg::S_ACC; c.sb = mce_pkg::S_NMI;
          ret_d = ST_L5; state_d = ST_WAIT;
        end
      end
      ST_L5: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_DEN;
        c.sa = mce_pkg::S_DEN; c.sb = mce_pkg::S_IP1;
        ret_d = ST_L6; state_d = ST_WAIT;
      end
      ST_L6: begin
        c.op = mce_pkg::OP_I_INC;
        state_d = ST_L4;
      end
      ST_L7: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_BASE; c.sa = mce_pkg::S_DEN;
        state_d = ST_L8;
      end
      ST_L8: begin
        c.op = mce_pkg::OP_E_PM2;
        pret_d = ST_L9; state_d = ST_PW0;
      end
      ST_L9: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_ACC;
        c.sa = mce_pkg::S_ACC; c.sb = mce_pkg::S_POW;
        ret_d = ST_OUT; state_d = ST_WAIT;
      end
      // surjection sum, i counting up to k
      ST_S0: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_ZERO;
        state_d = ST_S1;
      end
      ST_S1: begin
        c.op = mce_pkg::OP_I_ZERO;
        state_d = ST_S2;
      end
      ST_S2: begin
        c.op = mce_pkg::OP_READ; c.addr = mce_pkg::A_K;
        state_d = ST_S3;
      end
      ST_S3: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_TMP; c.sa = mce_pkg::S_FACT;
        state_d = ST_S4;
      end
      ST_S4: begin
        c.op = mce_pkg::OP_READ; c.addr = mce_pkg::A_KMI;
        state_d = ST_S5;
      end
      ST_S5: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
        c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_FINV;
        ret_d = ST_S6; state_d = ST_WAIT;
      end
      ST_S6: begin
        c.op = mce_pkg::OP_READ; c.addr = mce_pkg::A_I;
        state_d = ST_S7;
      end
      ST_S7: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
        c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_FINV;
        ret_d = ST_S8; state_d = ST_WAIT;
      end
      ST_S8: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_BASE; c.sa = mce_pkg::S_KMI;
        state_d = ST_S9;
      end
      ST_S9: begin
        c.op = mce_pkg::OP_E_N;
        pret_d = ST_S10; state_d = ST_PW0;
      end
      ST_S10: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
        c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_POW;
        ret_d = ST_S11; state_d = ST_WAIT;
      end
      ST_S11: begin
        c.op = stat_i.i_odd ? mce_pkg::OP_SUB : mce_pkg::OP_ADD;
        c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_ACC; c.sb = mce_pkg::S_TMP;
        state_d = ST_S12;
      end
      ST_S12: begin
        if (stat_i.i_eq_k) state_d = ST_OUT;
        else begin
          c.op = mce_pkg::OP_I_INC;
          state_d = ST_S2;
        end
      end
      // Bell sum, i walking down from m so the prefix grows a term a step
      ST_T0: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_ACC; c.sa = mce_pkg::S_ZERO;
        state_d = ST_T1;
      end
      ST_T1: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_PREF; c.sa = mce_pkg::S_ONE;
        state_d = ST_T2;
      end
      ST_T2: begin
        c.op = mce_pkg::OP_I_M;
        state_d = ST_T3;
      end
      ST_T3: begin
        if (stat_i.i_zero) state_d = ST_OUT;
        else if (stat_i.j_zero) state_d = ST_T5;
        else begin
          c.op = mce_pkg::OP_READ; c.addr = mce_pkg::A_J;
          state_d = ST_T4;
        end
      end
      ST_T4: begin
        c.op = stat_i.j_odd ? mce_pkg::OP_SUB : mce_pkg::OP_ADD;
        c.dst = mce_pkg::R_PREF; c.sa = mce_pkg::S_PREF; c.sb = mce_pkg::S_FINV;
        state_d = ST_T5;
      end
      ST_T5: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_BASE; c.sa = mce_pkg::S_I;
        state_d = ST_T6;
      end
      ST_T6: begin
        c.op = mce_pkg::OP_E_N;
        pret_d = ST_T7; state_d = ST_PW0;
      end
      ST_T7: begin
        c.op = mce_pkg::OP_LOAD; c.dst = mce_pkg::R_TMP; c.sa = mce_pkg::S_POW;
        state_d = ST_T8;
      end
      ST_T8: begin
        c.op = mce_pkg::OP_READ; c.addr = mce_pkg::A_I;
        state_d = ST_T9;
      end
      ST_T9: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
        c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_FINV;
        ret_d = ST_T10; state_d = ST_WAIT;
      end
      ST_T10: begin
        c.op = mce_pkg::OP_MUL; c.dst = mce_pkg::R_TMP;
        c.sa = mce_pkg::S_TMP; c.sb = mce_pkg::S_PREF;
        ret_d = ST_T11; state_d = ST_WAIT;
      end
      ST_T11: begin
        c.op = mce_pkg::OP_ADD; c.dst = mce_pkg::R_ACC;
        c.sa = mce_pkg::S_ACC; c.sb = mce_pkg::S_TMP;
        state_d = ST_T12;
      end
      ST_T12: begin
        c.op = mce_pkg::OP_I_DEC;
        state_d = ST_T3;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      pret_q    <= ST_IDLE;
      cmd_q     <= mce_pkg::CMD_C;
      tbl_rdy_q <= 1'b0;
      st_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      pret_q    <= pret_d;
      cmd_q     <= cmd_d;
      tbl_rdy_q <= tbl_rdy_d;
      st_q      <= st_d;
    end
  end

  assign dp_cmd_o    = c;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign status_o    = st_q;

endmodule

FILE: design/modular_combinatorics_engine_top.sv
// Surjection: 3 + bitlen(n) + popcount(n) multiplies a term, k+1 terms;
// Bell: 2 + bitlen(n) + popcount(n) multiplies a term, min(k,n) terms. First query after reset first
// builds the tables: 2*(TABLE_SIZE-1) + 45 multiplies (Fermat inverse is 45 of them).
// Throughput: one query at a time through the one bit-serial multiplier (30 bits a multiply).
// Reset: asynchronous, active low; tables are rebuilt on the first query after reset.
module modular_combinatorics_engine_top #(
  parameter int unsigned TABLE_SIZE = mce_pkg::DEF_TABLE_SIZE
) (
  input logic      clk_i,
  input logic      rst_ni,
  mce_in_if.sink   in_i,
  mce_out_if.source out_o
);

  mce_pkg::dp_cmd_t  dp_cmd;
  mce_pkg::dp_stat_t dp_stat;

  mce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_o    (out_o.status),
    .dp_cmd_o    (dp_cmd),
    .stat_i      (dp_stat)
  );

  mce_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (dp_cmd),
    .stat_o  (dp_stat),
    .n_i     (in_i.n),
    .k_i     (in_i.k),
    .value_o (out_o.value)
  );

endmodule
